>>> design/wwge_pkg.sv
package wwge_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  localparam int COL_W  = $clog2(GRID_WIDTH);
  localparam int STEP_W = $clog2(GRID_HEIGHT + 1);

  typedef enum logic [1:0] {
    KIND_EMPTY     = 2'd0,
    KIND_CONDUCTOR = 2'd1,
    KIND_TAIL      = 2'd2,
    KIND_HEAD      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEN_PRE,
    ST_GEN,
    ST_ACC_RD,
    ST_ACC_DO,
    ST_RESULT
  } state_e;

  typedef logic [GRID_WIDTH-1:0][1:0] row_t;

  // head flags of one column across the three-row window
  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } heads_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

>>> design/wwge_if.sv
interface wwge_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic [1:0] new_kind;

  modport source (output valid, operation, cell_x, cell_y, new_kind, input ready);
  modport sink   (input valid, operation, cell_x, cell_y, new_kind, output ready);
endinterface

interface wwge_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_kind;

  modport source (output valid, cell_kind, input ready);
  modport sink   (input valid, cell_kind, output ready);
endinterface

>>> design/wireworld_grid_engine_core.sv
// WireWorld grid engine. The grid is kept one row per memory word; a row of
// column cells holds a two-row window and computes the next row from it and
// the row arriving from memory, so one generation sweeps the grid row by row
// and writes each new row back in place; rows are read through the single
// row read port. A read or a write goes through ST_ACC_RD, ST_ACC_DO and
// ST_RESULT; a generation runs ST_GEN_PRE and ST_GEN, then the same steps.
// After reset the block clears the grid, one row per cycle, before it takes
// its first beat. A result waits in an output register while the next beat is accepted.
module wireworld_grid_engine_core
  import wwge_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  wwge_in_if.sink    in_i,
  wwge_out_if.source out_o
);

  state_e state_q, state_d;

  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        op_q, op_d;
  logic [5:0]        x_q, x_d;
  logic [5:0]        y_q, y_d;
  logic [1:0]        kind_q, kind_d;
  logic              in_grid_q, in_grid_d;
  logic [1:0]        res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_kind_q, out_kind_d;

  row_t             mem_q [GRID_HEIGHT];
  row_t             rd_q;
  logic             re, we;
  logic [ROW_W-1:0] raddr, waddr;
  row_t             wdata;

  cell_ctl_t  ctl;
  row_t       down_row, next_row;
  logic       in_ready, accept, load;
  logic [31:0] x_ext, y_ext;
  logic [ROW_W-1:0] y_row;
  logic [COL_W-1:0] x_col;
  logic [STEP_W-1:0] step_inc, step_dec;

  assign accept   = in_i.valid && in_ready;
  assign x_ext    = 32'(x_q);
  assign y_ext    = 32'(y_q);
  assign y_row    = y_ext[ROW_W-1:0];
  assign x_col    = x_ext[COL_W-1:0];
  assign step_inc = step_q + 1'b1;
  assign step_dec = step_q - 1'b1;

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.cell_kind = out_kind_q;

  wwge_cell_row u_row (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .down_i (down_row),
    .next_o (next_row)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (step_q == STEP_W'(GRID_HEIGHT - 1)) state_d = ST_IDLE;
      ST_IDLE:    if (accept) begin
        state_d = (in_i.operation == OP_ADVANCE) ? ST_GEN_PRE : ST_ACC_RD;
      end
      ST_GEN_PRE: state_d = ST_GEN;
      ST_GEN:     if (step_q == STEP_W'(GRID_HEIGHT)) state_d = ST_ACC_RD;
      ST_ACC_RD:  state_d = ST_ACC_DO;
      ST_ACC_DO:  state_d = ST_RESULT;
      ST_RESULT:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    op_d        = op_q;
    x_d         = x_q;
    y_d         = y_q;
    kind_d      = kind_q;
    in_grid_d   = in_grid_q;
    res_d       = res_q;
    in_ready    = 1'b0;
    load        = 1'b0;
    re          = 1'b0;
    we          = 1'b0;
    raddr       = '0;
    waddr       = '0;
    wdata       = '0;
    ctl         = '0;
    down_row    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        we     = 1'b1;
        waddr  = step_q[ROW_W-1:0];
        step_d = step_inc;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          op_d      = in_i.operation;
          x_d       = in_i.cell_x;
          y_d       = in_i.cell_y;
          kind_d    = in_i.new_kind;
          in_grid_d = (32'(in_i.cell_x) < 32'(GRID_WIDTH))
                   && (32'(in_i.cell_y) < 32'(GRID_HEIGHT));
          step_d    = '0;
        end
      end
      ST_GEN_PRE: begin
        re        = 1'b1;
        ctl.clear = 1'b1;
      end
      ST_GEN: begin
        ctl.shift = 1'b1;
        down_row  = (step_q < STEP_W'(GRID_HEIGHT)) ? rd_q : '0;
        re        = (step_inc < STEP_W'(GRID_HEIGHT));
        raddr     = step_inc[ROW_W-1:0];
        we        = (step_q != '0);
        waddr     = step_dec[ROW_W-1:0];
        wdata     = next_row;
        step_d    = step_inc;
      end
      ST_ACC_RD: begin
        re    = in_grid_q;
        raddr = y_row;
      end
      ST_ACC_DO: begin
        if (op_q == OP_WRITE && in_grid_q) begin
          we           = 1'b1;
          waddr        = y_row;
          wdata        = rd_q;
          wdata[x_col] = kind_q;
          res_d        = kind_q;
        end else begin
          res_d = in_grid_q ? rd_q[x_col] : KIND_EMPTY;
        end
      end
      ST_RESULT: begin
        load = !out_valid_q || out_o.ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_kind_d  = res_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    x_q        <= x_d;
    y_q        <= y_d;
    kind_q     <= kind_d;
    in_grid_q  <= in_grid_d;
    res_q      <= res_d;
    out_kind_q <= out_kind_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

endmodule

>>> design/wwge_cell.sv
module wwge_cell
  import wwge_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  logic [1:0] down_i,
  input  heads_t     left_i,
  input  heads_t     right_i,
  output heads_t     heads_o,
  output logic [1:0] next_o
);

  logic [1:0] up_q, up_d;
  logic [1:0] mid_q, mid_d;
  logic [3:0] cnt;

  assign heads_o.up   = (up_q == KIND_HEAD);
  assign heads_o.mid  = (mid_q == KIND_HEAD);
  assign heads_o.down = (down_i == KIND_HEAD);

  assign cnt = 4'(left_i.up) + 4'(left_i.mid) + 4'(left_i.down)
             + 4'(heads_o.up) + 4'(heads_o.down)
             + 4'(right_i.up) + 4'(right_i.mid) + 4'(right_i.down);

  always_comb begin
    case (mid_q)
      KIND_HEAD:      next_o = KIND_TAIL;
      KIND_TAIL:      next_o = KIND_CONDUCTOR;
      KIND_CONDUCTOR: next_o = (cnt == 4'd1 || cnt == 4'd2) ? KIND_HEAD : KIND_CONDUCTOR;
      default:        next_o = KIND_EMPTY;
    endcase
  end

  always_comb begin
    up_d  = up_q;
    mid_d = mid_q;
    if (ctl_i.clear) begin
      up_d  = KIND_EMPTY;
      mid_d = KIND_EMPTY;
    end else if (ctl_i.shift) begin
      up_d  = mid_q;
      mid_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    mid_q <= mid_d;
  end

endmodule

>>> design/wwge_cell_row.sv
module wwge_cell_row
  import wwge_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  row_t      down_i,
  output row_t      next_o
);

  heads_t heads [GRID_WIDTH];

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    heads_t left, right;

    if (c == 0) begin : g_lo
      assign left = '0;
    end else begin : g_lm
      assign left = heads[c-1];
    end

    if (c == GRID_WIDTH - 1) begin : g_hi
      assign right = '0;
    end else begin : g_rm
      assign right = heads[c+1];
    end

    wwge_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .down_i  (down_i[c]),
      .left_i  (left),
      .right_i (right),
      .heads_o (heads[c]),
      .next_o  (next_o[c])
    );
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import wwge_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;  // unused code, behaves as a read
  localparam int IDLE_LIMIT = 2000;
  localparam int CALM_TAIL  = 120;
  localparam int TARGET     = 750;

  typedef struct {
    logic [1:0] op;
    logic [5:0] x;
    logic [5:0] y;
    logic [1:0] kind;
    bit         drain;  // wait until all results are back before sending
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wwge_in_if  in_if ();
  wwge_out_if out_if ();

  wireworld_grid_engine_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  cmd_t  pending_cmds[$];
  kind_e due_kinds[$];
  kind_e grid_state[GRID_HEIGHT][GRID_WIDTH];
  kind_e next_grid[GRID_HEIGHT][GRID_WIDTH];
  int    mismatches = 0;
  int    cmd_count = 0;

  function automatic int heads_around(int x, int y);
    int n;
    n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if ((dx != 0 || dy != 0) && x + dx >= 0 && y + dy >= 0 &&
            x + dx < GRID_WIDTH && y + dy < GRID_HEIGHT &&
            grid_state[y+dy][x+dx] == KIND_HEAD) begin
          n++;
        end
      end
    end
    return n;
  endfunction

  function automatic void step_generation();
    int h;
    for (int y = 0; y < GRID_HEIGHT; y++) begin
      for (int x = 0; x < GRID_WIDTH; x++) begin
        case (grid_state[y][x])
          KIND_HEAD: next_grid[y][x] = KIND_TAIL;
          KIND_TAIL: next_grid[y][x] = KIND_CONDUCTOR;
          KIND_CONDUCTOR: begin
            h = heads_around(x, y);
            next_grid[y][x] = (h == 1 || h == 2) ? KIND_HEAD : KIND_CONDUCTOR;
          end
          default: next_grid[y][x] = KIND_EMPTY;
        endcase
      end
    end
    grid_state = next_grid;
  endfunction

  function automatic kind_e predict_cell_kind(cmd_t c);
    if (c.op == OP_WRITE) begin
      grid_state[c.y][c.x] = kind_e'(c.kind);
    end else if (c.op == OP_ADVANCE) begin
      step_generation();
    end
    return grid_state[c.y][c.x];
  endfunction

  task automatic add_cmd(input logic [1:0] op, input int x, input int y,
                         input logic [1:0] kind, input bit drain);
    cmd_t c;
    c.op    = op;
    c.x     = x[5:0];
    c.y     = y[5:0];
    c.kind  = kind;
    c.drain = drain;
    pending_cmds = {pending_cmds, c};
    cmd_count++;
  endtask

  function automatic kind_e random_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return KIND_CONDUCTOR;
    if (r < 7) return KIND_HEAD;
    if (r < 8) return KIND_TAIL;
    return KIND_EMPTY;
  endfunction

  function automatic int random_corner();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 0 : GRID_WIDTH - 4;
    return $urandom_range(0, GRID_WIDTH - 4);
  endfunction

  // driver
  cmd_t cur_cmd;
  int   gap_left = 0;

  always @(posedge clk_i) begin : drive
    bit fire;
    bit calm;
    fire = in_if.valid && in_if.ready;
    calm = pending_cmds.size() < CALM_TAIL;
    if (rst_ni) begin
      if (fire) begin
        due_kinds = {due_kinds, predict_cell_kind(cur_cmd)};
      end
      if (!(in_if.valid && !fire)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && due_kinds.size() != 0)) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 9) - 1;
            in_if.valid <= 1'b0;
          end else begin
            cur_cmd = pending_cmds.pop_front();
            in_if.operation <= cur_cmd.op;
            in_if.cell_x    <= cur_cmd.x;
            in_if.cell_y    <= cur_cmd.y;
            in_if.new_kind  <= cur_cmd.kind;
            in_if.valid     <= 1'b1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left = 0;

  always @(posedge clk_i) begin : observe
    kind_e want;
    bit calm;
    calm = pending_cmds.size() < CALM_TAIL;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (due_kinds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: cell_kind %0d", out_if.cell_kind);
        end else begin
          want = due_kinds.pop_front();
          if (out_if.cell_kind !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cell_kind mismatch: expected %0d, got %0d", want, out_if.cell_kind);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int x0;
    int y0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_READ;
    in_if.cell_x    = '0;
    in_if.cell_y    = '0;
    in_if.new_kind  = KIND_EMPTY;
    out_if.ready    = 1'b0;
    for (int y = 0; y < GRID_HEIGHT; y++) begin
      for (int x = 0; x < GRID_WIDTH; x++) begin
        grid_state[y][x] = KIND_EMPTY;
      end
    end

    // corners and edges; stale new_kind on reads must be ignored
    add_cmd(OP_READ, 0, 0, KIND_HEAD, 0);
    add_cmd(OP_WRITE, 0, 0, KIND_HEAD, 0);
    add_cmd(OP_WRITE, 1, 0, KIND_CONDUCTOR, 0);
    add_cmd(OP_WRITE, 0, 1, KIND_CONDUCTOR, 0);
    add_cmd(OP_WRITE, 1, 1, KIND_CONDUCTOR, 0);
    // three heads around a conductor: stays conductor
    add_cmd(OP_WRITE, 63, 63, KIND_CONDUCTOR, 0);
    add_cmd(OP_WRITE, 62, 63, KIND_HEAD, 0);
    add_cmd(OP_WRITE, 63, 62, KIND_HEAD, 0);
    add_cmd(OP_WRITE, 62, 62, KIND_HEAD, 0);
    // two heads: becomes head
    add_cmd(OP_WRITE, 63, 0, KIND_CONDUCTOR, 0);
    add_cmd(OP_WRITE, 62, 0, KIND_HEAD, 0);
    add_cmd(OP_WRITE, 62, 1, KIND_HEAD, 0);
    add_cmd(OP_WRITE, 0, 63, KIND_TAIL, 0);
    add_cmd(OP_WRITE, 1, 63, KIND_TAIL, 0);
    add_cmd(OP_WRITE, 1, 63, KIND_EMPTY, 0);
    add_cmd(OP_ADVANCE, 1, 1, KIND_HEAD, 0);
    add_cmd(OP_SPARE, 0, 0, KIND_CONDUCTOR, 0);
    add_cmd(OP_READ, 63, 63, KIND_EMPTY, 0);
    add_cmd(OP_READ, 63, 0, KIND_TAIL, 0);
    add_cmd(OP_SPARE, 0, 63, KIND_HEAD, 0);
    add_cmd(OP_ADVANCE, 62, 62, KIND_EMPTY, 1);
    add_cmd(OP_READ, 1, 1, KIND_EMPTY, 0);
    add_cmd(OP_READ, 0, 1, KIND_TAIL, 0);

    while (cmd_count < TARGET) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        x0 = random_corner();
        y0 = random_corner();
        repeat ($urandom_range(4, 12)) begin
          add_cmd(OP_WRITE, x0 + $urandom_range(0, 3), y0 + $urandom_range(0, 3),
                  random_kind(), 0);
        end
        add_cmd(OP_ADVANCE, x0 + $urandom_range(0, 3), y0 + $urandom_range(0, 3),
                2'($urandom_range(0, 3)), $urandom_range(0, 19) == 0);
        repeat ($urandom_range(0, 4)) begin
          add_cmd(OP_ADVANCE, x0 + $urandom_range(0, 3), y0 + $urandom_range(0, 3),
                  2'($urandom_range(0, 3)), 0);
        end
        repeat ($urandom_range(1, 3)) begin
          add_cmd($urandom_range(0, 1) ? OP_READ : OP_SPARE, x0 + $urandom_range(0, 3),
                  y0 + $urandom_range(0, 3), 2'($urandom_range(0, 3)), 0);
        end
      end else if (r < 92) begin
        add_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                2'($urandom_range(0, 3)), 0);
      end else begin
        add_cmd(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                2'($urandom_range(0, 3)), 0);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || due_kinds.size() != 0 || in_if.valid) begin
      @(posedge clk_i);
    end
    repeat (GRID_HEIGHT + 16) @(posedge clk_i);

    if (mismatches == 0 && due_kinds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
